[hdl/sslt_pkg.sv]
// Shared types and constants for the sync slicer level tuner.
`default_nettype none

package sslt_pkg;

	// Fixed field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned BITS_W  = 16;
	localparam int unsigned LEVEL_W = 5;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 4;

	// Sample lanes: each lane counts a group of samples
	localparam int unsigned SAMPLES      = 16;
	localparam int unsigned LANE_SAMPLES = 4;
	localparam int unsigned LANES        = SAMPLES / LANE_SAMPLES;
	localparam int unsigned LANE_CNT_W   = $clog2(LANE_SAMPLES + 1);
	localparam int unsigned CNT_W        = $clog2(SAMPLES + 1);

	// Level limits
	localparam int unsigned LEVEL_MAX        = 31;
	localparam int unsigned LowestSteppable  = 2;
	localparam int unsigned LowestTrimmable  = 8;

	// Register reset values
	localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 16'd1000;
	localparam logic [CFG_W-1:0] STEP_TH_RST    = 16'd8;
	localparam logic [CFG_W-1:0] HANDOVER_RST   = 16'd32;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW_LEN  = 4'd0,
		REG_STEP_TH     = 4'd1,
		REG_HANDOVER_TH = 4'd2,
		REG_START_LEVEL = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              sync_path_active;
		logic              source_disturbed;
		logic              slicer_fault_flag;
		logic              source_classified;
		logic [TIME_W-1:0] time_ms;
		logic [BITS_W-1:0] trouble_bits;
		logic [BITS_W-1:0] line_moved_bits;
	} in_item_t;

	typedef struct packed {
		logic               level_moved;
		logic               phase_stale;
		logic               source_unsettled;
		logic               escalate;
		logic               apply_level;
		logic [LEVEL_W-1:0] level_now;
	} out_item_t;

	// Register write toward the tuner core
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] index;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	typedef logic [LANES-1:0][LANE_CNT_W-1:0] lane_cnt_t;

endpackage

`default_nettype wire

[hdl/sslt_lane.sv]
// One sample lane: flags bad samples in its group and counts them.
`default_nettype none

module sslt_lane
	import sslt_pkg::*;
(
	input  wire logic [LANE_SAMPLES-1:0] trouble,
	input  wire logic [LANE_SAMPLES-1:0] line_moved,
	input  wire logic                    classified,
	output      logic [LANE_CNT_W-1:0]   count
);

	logic [LANE_SAMPLES-1:0] bad;

	// A sample is bad on trouble, unless the line is classified and did not move
	assign bad = classified ? (trouble & line_moved) : trouble;

	// Group popcount
	always_comb begin
		count = '0;
		for (int i = 0; i < LANE_SAMPLES; i++) begin
			count = count + LANE_CNT_W'(bad[i]);
		end
	end

endmodule

`default_nettype wire

[hdl/sslt_core.sv]
// Tuner core: merges lane counts, holds level/window state and registers.
`default_nettype none

module sslt_core
	import sslt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_acc,
	input  wire in_item_t  item,
	input  wire lane_cnt_t lane_cnt,
	input  wire cfg_wr_t   cfg_wr,
	output      out_item_t result
);

	logic [CFG_W-1:0]   wlen_q, step_th_q, hand_th_q;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic [TIME_W-1:0]  wbeg_q, wbeg_d;
	logic [CFG_W-1:0]   bad_q, bad_d;
	logic               stepped_q, stepped_d;

	logic [CNT_W-1:0]   counted;
	logic               disturb, restart, closed;
	logic [TIME_W-1:0]  elapsed;
	logic [CFG_W-1:0]   bad_base, bad_sat;
	logic [CFG_W:0]     bad_sum;

	// Merge: total bad samples over all lanes
	always_comb begin
		counted = '0;
		for (int l = 0; l < LANES; l++) begin
			counted = counted + CNT_W'(lane_cnt[l]);
		end
	end

	// Window timing, modulo 2^32
	assign disturb  = item.source_disturbed | item.slicer_fault_flag;
	assign elapsed  = item.time_ms - wbeg_q;
	assign restart  = disturb && (elapsed > TIME_W'(wlen_q));
	// After a restart the elapsed time is zero
	assign closed   = restart ? (wlen_q == '0) : (elapsed >= TIME_W'(wlen_q));
	assign bad_base = restart ? '0 : bad_q;
	assign bad_sum  = {1'b0, bad_base} + (CFG_W + 1)'(counted);
	assign bad_sat  = bad_sum[CFG_W] ? '1 : bad_sum[CFG_W-1:0];

	// Pass update
	always_comb begin
		level_d   = level_q;
		wbeg_d    = wbeg_q;
		bad_d     = bad_q;
		stepped_d = stepped_q;
		result    = '0;
		if (item.sync_path_active) begin
			wbeg_d = restart ? item.time_ms : wbeg_q;
			bad_d  = bad_base;
			result.source_unsettled = disturb;
			if (closed) begin
				// Window close: give back one earned step
				if (stepped_q) begin
					stepped_d = 1'b0;
					if (level_q >= LEVEL_W'(LowestTrimmable)) begin
						level_d            = level_q - 1'b1;
						bad_d              = '0;
						result.level_moved = 1'b1;
						result.phase_stale = 1'b1;
						result.apply_level = 1'b1;
					end
				end
			end else begin
				bad_d = bad_sat;
				if (counted != '0) begin
					result.source_unsettled = 1'b1;
				end
				if (bad_sat >= step_th_q) begin
					if (level_q >= LEVEL_W'(LowestSteppable)) begin
						level_d            = level_q - 1'b1;
						bad_d              = '0;
						result.apply_level = 1'b1;
						result.level_moved = 1'b1;
						stepped_d          = 1'b1;
					end else if (bad_sat > hand_th_q) begin
						bad_d              = '0;
						result.escalate    = 1'b1;
						result.level_moved = 1'b1;
						stepped_d          = 1'b1;
					end
					wbeg_d = item.time_ms;
				end
			end
		end
		result.level_now = level_d;
	end

	// State and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= WINDOW_LEN_RST;
			step_th_q <= STEP_TH_RST;
			hand_th_q <= HANDOVER_RST;
			level_q   <= '0;
			wbeg_q    <= '0;
			bad_q     <= '0;
			stepped_q <= 1'b0;
		end else if (cfg_wr.en) begin
			case (cfg_wr.index)
				REG_WINDOW_LEN:  wlen_q    <= cfg_wr.data;
				REG_STEP_TH:     step_th_q <= cfg_wr.data;
				REG_HANDOVER_TH: hand_th_q <= cfg_wr.data;
				REG_START_LEVEL: begin
					if (32'(cfg_wr.data[LEVEL_W-1:0]) <= LEVEL_MAX) begin
						level_q <= cfg_wr.data[LEVEL_W-1:0];
					end
				end
				default: ;
			endcase
		end else if (item_acc) begin
			level_q   <= level_d;
			wbeg_q    <= wbeg_d;
			bad_q     <= bad_d;
			stepped_q <= stepped_d;
		end
	end

endmodule

`default_nettype wire

[hdl/sync_slicer_level_tuner.sv]
// Top level of the sync slicer level tuner: lanes, core and output skid buffer.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------
//  in      | in_valid / in_stall    | in_item  (in_item_t)
//  out     | out_valid / out_stall  | out_item (out_item_t)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (16 bit)
//
// One pass is accepted per cycle unless in_stall is high; its result goes to
// out_q, or to skid_q while out_stall holds out_q. The rate is set by the
// combinational level/window/count update on the state registers. arst_n clears
// state, registers go to their defaults. A two-entry buffer absorbs out_stall;
// in_stall rises only when both entries hold results. cfg_ready is always high.
`default_nettype none

module sync_slicer_level_tuner
	import sslt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_stall,
	input  wire in_item_t         in_item,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      out_item_t        out_item,
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	lane_cnt_t lane_cnt;
	cfg_wr_t   cfg_wr;
	out_item_t result, out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      in_acc, out_free;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = '{en: cfg_valid & cfg_ready, index: cfg_index, data: cfg_data};

	// Sample lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		sslt_lane u_lane (
			.trouble    (in_item.trouble_bits[g*LANE_SAMPLES +: LANE_SAMPLES]),
			.line_moved (in_item.line_moved_bits[g*LANE_SAMPLES +: LANE_SAMPLES]),
			.classified (in_item.source_classified),
			.count      (lane_cnt[g])
		);
	end

	sslt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_acc (in_acc),
		.item     (in_item),
		.lane_cnt (lane_cnt),
		.cfg_wr   (cfg_wr),
		.result   (result)
	);

	// Handshake
	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Output skid buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | in_acc;
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output skid buffer payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (in_acc) begin
			skid_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> out_valid_q)
		else $error("buffered result lost");

	a_apply_moves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.apply_level |-> out_item.level_moved)
		else $error("level applied without a move");

	a_escalate_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.escalate |-> !out_item.apply_level && !out_item.phase_stale)
		else $error("escalation together with a level change");
`endif

endmodule

`default_nettype wire

[tb/tb_sync_slicer_level_tuner.sv]
// Self-checking testbench for the sync slicer level tuner.
`timescale 1ns / 1ps

module tb_sync_slicer_level_tuner;
	import sslt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PRINT_CAP   = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_item = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	sync_slicer_level_tuner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Tuner state as the testbench sees it
	logic [CFG_W-1:0]   win_len     = WINDOW_LEN_RST;
	logic [CFG_W-1:0]   step_th     = STEP_TH_RST;
	logic [CFG_W-1:0]   handover_th = HANDOVER_RST;
	logic [LEVEL_W-1:0] lvl         = '0;
	logic [TIME_W-1:0]  win_begin   = '0;
	logic [15:0]        bad_cnt     = '0;
	logic               stepped     = 1'b0;

	// Passes waiting to go out, results owed by the tuner
	in_item_t    pending_passes[$];
	out_item_t   tuner_verdicts[$];
	int unsigned passes_queued = 0;
	int unsigned passes_sent   = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;

	// Idle shaping
	int unsigned in_gap_max    = 0;
	int unsigned out_stall_max = 0;
	int unsigned drain_odds    = 0;
	logic        drain_hold    = 1'b0;
	int unsigned gap_left      = 0;
	int unsigned stall_left    = 0;
	logic [TIME_W-1:0] now_ms  = '0;

	// One tuning pass: returns the result and advances the tuner state
	function automatic out_item_t tune_pass(input in_item_t p);
		out_item_t          r;
		logic [TIME_W-1:0]  span;
		logic [BITS_W-1:0]  bad_bits;
		logic [16:0]        sum;
		r = '0;
		if (p.sync_path_active) begin
			// a disturbance after the window ran out restarts it
			if (p.source_disturbed || p.slicer_fault_flag) begin
				span = p.time_ms - win_begin;
				if (span > TIME_W'(win_len)) begin
					bad_cnt = '0;
					win_begin = p.time_ms;
				end
				r.source_unsettled = 1'b1;
			end
			span = p.time_ms - win_begin;
			if (span >= TIME_W'(win_len)) begin
				// window closed: give back one earned step
				if (stepped) begin
					stepped = 1'b0;
					if (lvl >= LowestTrimmable) begin
						lvl = lvl - 1'b1;
						bad_cnt = '0;
						r.level_moved = 1'b1;
						r.phase_stale = 1'b1;
						r.apply_level = 1'b1;
					end
				end
			end else begin
				bad_bits = p.source_classified ? (p.trouble_bits & p.line_moved_bits)
					: p.trouble_bits;
				sum = {1'b0, bad_cnt} + 17'($countones(bad_bits));
				bad_cnt = sum[16] ? 16'hFFFF : sum[15:0];
				if (bad_bits != '0)
					r.source_unsettled = 1'b1;
				if (bad_cnt >= step_th) begin
					if (lvl >= LowestSteppable) begin
						lvl = lvl - 1'b1;
						bad_cnt = '0;
						r.apply_level = 1'b1;
						r.level_moved = 1'b1;
					end else if (bad_cnt > handover_th) begin
						r.escalate = 1'b1;
						bad_cnt = '0;
						r.level_moved = 1'b1;
					end
					if (r.level_moved)
						stepped = 1'b1;
					win_begin = p.time_ms;
				end
			end
		end
		r.level_now = lvl;
		return r;
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
		case (idx)
			REG_WINDOW_LEN:  win_len = d;
			REG_STEP_TH:     step_th = d;
			REG_HANDOVER_TH: handover_th = d;
			REG_START_LEVEL: lvl = d[LEVEL_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic in_item_t pass_of(input logic sync, input logic disturbed,
			input logic fault, input logic cls, input logic [TIME_W-1:0] t,
			input logic [BITS_W-1:0] trouble, input logic [BITS_W-1:0] moved);
		in_item_t p;
		p.sync_path_active  = sync;
		p.source_disturbed  = disturbed;
		p.slicer_fault_flag = fault;
		p.source_classified = cls;
		p.time_ms           = t;
		p.trouble_bits      = trouble;
		p.line_moved_bits   = moved;
		return p;
	endfunction

	// Random pass; time mostly creeps forward within the window, sometimes past it
	function automatic in_item_t random_pass();
		in_item_t    p;
		int unsigned pick;
		p.sync_path_active  = ($urandom_range(0, 9) != 0);
		p.source_disturbed  = ($urandom_range(0, 11) == 0);
		p.slicer_fault_flag = ($urandom_range(0, 11) == 0);
		p.source_classified = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 15)
			now_ms = now_ms;
		else if (pick < 60)
			now_ms = now_ms + $urandom_range(0, win_len / 4 + 1);
		else if (pick < 88)
			now_ms = now_ms + $urandom_range(0, win_len);
		else if (pick < 97)
			now_ms = now_ms + win_len + $urandom_range(0, win_len);
		else
			now_ms = $urandom;
		p.time_ms = now_ms;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			p.trouble_bits = '0;
		else if (pick == 1)
			p.trouble_bits = 16'($urandom & $urandom & $urandom);
		else
			p.trouble_bits = 16'($urandom);
		p.line_moved_bits = 16'($urandom);
		return p;
	endfunction

	task automatic add_pass(input in_item_t p);
		pending_passes.push_back(p);
		passes_queued++;
	endtask

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			flag_mismatch($sformatf("result %0d %s: want %0d got %0d",
				results_seen, name, want, got));
	endtask

	// Register write; valid stays up so back-to-back writes need no re-raise
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
	endtask

	task automatic configure(input logic [CFG_W-1:0] wlen, input logic [CFG_W-1:0] sth,
			input logic [CFG_W-1:0] hth, input logic [CFG_W-1:0] slv);
		write_reg(REG_WINDOW_LEN, wlen);
		write_reg(REG_STEP_TH, sth);
		write_reg(REG_HANDOVER_TH, hth);
		write_reg(REG_START_LEVEL, slv);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (passes_sent != passes_queued || tuner_verdicts.size() != 0);
	endtask

	// Input driver: one transaction per pending pass, random gap after each
	always @(posedge clk) begin
		logic busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				tuner_verdicts.push_back(tune_pass(in_item));
				passes_sent++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_passes.size() != 0
						&& !(drain_hold && tuner_verdicts.size() != 0)) begin
					in_item  <= pending_passes.pop_front();
					in_valid <= 1'b1;
					gap_left = $urandom_range(0, in_gap_max);
					drain_hold = (drain_odds != 0) && ($urandom_range(1, drain_odds) == 1);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tuner_verdicts.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with nothing owed", results_seen));
				end else begin
					want = tuner_verdicts.pop_front();
					cmp_field("level_moved", 32'(want.level_moved),
						32'(out_item.level_moved));
					cmp_field("phase_stale", 32'(want.phase_stale),
						32'(out_item.phase_stale));
					cmp_field("source_unsettled", 32'(want.source_unsettled),
						32'(out_item.source_unsettled));
					cmp_field("escalate", 32'(want.escalate), 32'(out_item.escalate));
					cmp_field("apply_level", 32'(want.apply_level),
						32'(out_item.apply_level));
					cmp_field("level_now", 32'(want.level_now), 32'(out_item.level_now));
				end
				results_seen++;
				stall_left = $urandom_range(0, out_stall_max);
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	// Stimulus sequence
	initial begin
		int unsigned k;
		logic [CFG_W-1:0] wlen, sth, hth, slv;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Defaults after reset: inactive path, accumulate, escalate at floor, empty trim,
		// disturbance exactly at and just past the window length
		add_pass(pass_of(1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b0, 32'd10, 16'hFFFF, 16'h0000));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b1, 32'd20, 16'hFFFF, 16'hFFFF));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b1, 32'd30, 16'hFFFF, 16'h8000));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b1, 32'd1030, 16'hFFFF, 16'hFFFF));
		add_pass(pass_of(1'b1, 1'b1, 1'b0, 1'b1, 32'd1030, 16'h0000, 16'h0000));
		add_pass(pass_of(1'b1, 1'b0, 1'b1, 1'b0, 32'd1031, 16'h0001, 16'h0000));
		wait_drained();

		// Shortest window: step to 8, trim to 7, then a step below the trim floor;
		// start level carries junk in the upper data bits
		configure(16'd1, 16'd2, 16'd0, 16'hFFE9);
		add_pass(pass_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd5000, 16'h0000, 16'h0000));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b1, 32'd5000, 16'h0003, 16'h0003));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b1, 32'd5001, 16'h0000, 16'h0000));
		add_pass(pass_of(1'b1, 1'b1, 1'b0, 1'b0, 32'd5001, 16'h0000, 16'h0000));
		add_pass(pass_of(1'b1, 1'b0, 1'b1, 1'b0, 32'd5002, 16'h0001, 16'h0000));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b0, 32'd5002, 16'h0001, 16'hFFFF));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b0, 32'd5003, 16'h0000, 16'h0000));
		wait_drained();

		// Zero step threshold, longest window, time wrapping through zero
		configure(16'hFFFF, 16'd0, 16'd0, 16'd2);
		add_pass(pass_of(1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0, 16'h0000, 16'h0000));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0005, 16'h0001, 16'h0000));
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b1, 32'h0000_0008, 16'hFFFF, 16'h0000));
		wait_drained();

		// Long run of bad samples at the floor up to escalate, then a zero threshold
		configure(16'hFFFF, 16'd1, 16'd600, 16'd0);
		repeat (40)
			add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b0, 32'd100, 16'hFFFF, 16'h0000));
		wait_drained();
		configure(16'hFFFF, 16'd1, 16'd0, 16'd0);
		add_pass(pass_of(1'b1, 1'b0, 1'b0, 1'b0, 32'd100, 16'h0001, 16'h0000));
		wait_drained();

		// Random phases, one setting each; a drain pause now and then
		drain_odds = 30;
		for (k = 0; k < 15; k++) begin
			if (k == 0) begin
				wlen = 16'hFFFF; sth = 16'hFFFF; hth = 16'hFFFF; slv = 16'd31;
			end else if (k == 1) begin
				wlen = 16'd1; sth = 16'd1; hth = 16'd0; slv = 16'd31;
			end else begin
				wlen = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 65535))
					: 16'($urandom_range(2, 40));
				sth  = (k == 2) ? 16'd0 : 16'($urandom_range(1, 10));
				hth  = 16'($urandom_range(0, 24));
				slv  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 31))
					: 16'($urandom_range(8, 31));
			end
			in_gap_max    = (k % 2 == 1) ? 11 : 0;
			out_stall_max = ((k / 2) % 2 == 1) ? 11 : 0;
			configure(wlen, sth, hth, slv);
			now_ms = (k == 3) ? 32'hFFFF_FFC0 : $urandom;
			// open a fresh window at the start of the phase
			add_pass(pass_of(1'b1, 1'b1, 1'b0, 1'b0, now_ms, 16'h0000, 16'h0000));
			repeat (55)
				add_pass(random_pass());
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
